// File: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the steering controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/dgps_pkg.sv
// Constants of the quadratic gain PD steering controller.
package dgps_pkg;

   // Configuration register indexes.
   localparam logic [1:0] REG_BASE_GAIN      = 2'd0;
   localparam logic [1:0] REG_DIFF_GAIN      = 2'd1;
   localparam logic [1:0] REG_SQUARE_DIVISOR = 2'd2;
   localparam logic [1:0] REG_SERVO_CENTER   = 2'd3;

   // Configuration reset values.
   localparam logic [7:0]  BASE_GAIN_RESET      = 8'd17;
   localparam logic [7:0]  DIFF_GAIN_RESET      = 8'd23;
   localparam logic [7:0]  SQUARE_DIVISOR_RESET = 8'd20;
   localparam logic [15:0] SERVO_CENTER_RESET   = 16'd0;

   // Last step indexes of the serial multiplier passes and of the divider.
   localparam logic [5:0] MUL_LAST = 6'd11;
   localparam logic [5:0] DIV_LAST = 6'd36;

   // Limits of the saturated command.
   localparam logic [31:0] CMD_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] CMD_MIN = 32'h8000_0000;

   typedef logic signed [12:0] error_type;

endpackage

// File: hw/rtl/dynamic_gain_pd_steering.sv
// Top level of the PD steering controller with quadratic gain scheduling.
//
//   channel   direction   handshake                   payload
//   req       in          req_tvalid / req_tready     tdata: measured, target
//   rsp       out         rsp_tvalid / rsp_tready     tdata: steer_command, tuser: clipped
//   csr       in          csr_valid / csr_ready       csr_index, csr_data
//
// A word is accepted only in the idle state; it then passes through two 12-step
// bit-serial multiplier passes, a sum and an absolute-value state that form and
// fold the numerator, a 37-step restoring divider by the square divisor, and a
// finish and an output state. Reset is synchronous and active high.
// A finished result waits in the output register while the next word is taken;
// the block only holds in its last step when that register is still occupied.
`include "assert_macros.svh"

module dynamic_gain_pd_steering
   import dgps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input words.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [11:0] measured, [23:12] target
   // Result words.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] steer_command
   output logic        rsp_tuser,   // [0] clipped
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_MUL2 = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_ABS  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [5:0]         cnt_ff, cnt_in;

   logic [7:0]         base_gain_ff, diff_gain_ff, sq_div_ff;
   logic [15:0]        servo_center_ff;

   error_type          prior_ff, prior_in;
   logic [11:0]        mag_ff, mag_in;
   logic               eneg_ff, eneg_in;
   logic [7:0]         tdiv_ff, tdiv_in;

   // Multiplier lane a: square, then cube of the error magnitude.
   logic [11:0]        mplr_a_ff, mplr_a_in;
   logic [35:0]        mc_a_ff, mc_a_in, acc_a_ff, acc_a_in;
   // Lane b: base gain times error, then divisor times the PD sum.
   logic [7:0]         mplr_b_ff, mplr_b_in;
   logic signed [30:0] mc_b_ff, mc_b_in, acc_b_ff, acc_b_in;
   // Lane c: derivative gain times the error difference.
   logic [7:0]         mplr_c_ff, mplr_c_in;
   logic signed [21:0] mc_c_ff, mc_c_in, acc_c_ff, acc_c_in;

   logic signed [37:0] num_ff, num_in;
   logic               num_neg_ff, num_neg_in;
   logic [36:0]        div_ff, div_in;
   logic [7:0]         rem_ff, rem_in;
   logic signed [38:0] cmd_ff, cmd_in;

   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]        rsp_tdata_ff, rsp_tdata_in;
   logic               rsp_tuser_ff, rsp_tuser_in;

   // Combinational helpers.
   logic               req_fire, rsp_free;
   error_type          err;
   logic [12:0]        err_abs;
   logic signed [13:0] delta;
   logic [35:0]        a_sum;
   logic signed [30:0] b_sum, k_val;
   logic signed [21:0] c_sum;
   logic [8:0]         trial, trial_diff;
   logic               trial_ge;
   logic signed [37:0] num_negated;
   logic [7:0]         sat_hi;
   logic               sat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // Error, its magnitude and its difference to the previous error.
   assign err     = {req_tdata[23], req_tdata[23:12]} - {req_tdata[11], req_tdata[11:0]};
   assign err_abs = err[12] ? 13'(-err) : 13'(err);
   assign delta   = {err[12], err} - {prior_ff[12], prior_ff};

   // One shift-add step on each multiplier lane.
   assign a_sum = acc_a_ff + (mplr_a_ff[0] ? mc_a_ff : 36'd0);
   assign b_sum = acc_b_ff + (mplr_b_ff[0] ? mc_b_ff : 31'sd0);
   assign c_sum = acc_c_ff + (mplr_c_ff[0] ? mc_c_ff : 22'sd0);
   assign k_val = b_sum + {{9{c_sum[21]}}, c_sum};

   // Restoring division step on the magnitude of the numerator.
   assign trial      = {rem_ff, div_ff[36]};
   assign trial_diff = trial - {1'b0, tdiv_ff};
   assign trial_ge   = (trial >= {1'b0, tdiv_ff});

   assign num_negated = -num_ff;

   // Saturation of the command to 32 bits.
   assign sat_hi = cmd_ff[38:31];
   assign sat    = !((sat_hi == 8'h00) || (sat_hi == 8'hFF));

   // Sequencer and datapath next values.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      prior_in      = prior_ff;
      mag_in        = mag_ff;
      eneg_in       = eneg_ff;
      tdiv_in       = tdiv_ff;
      mplr_a_in     = mplr_a_ff;
      mc_a_in       = mc_a_ff;
      acc_a_in      = acc_a_ff;
      mplr_b_in     = mplr_b_ff;
      mc_b_in       = mc_b_ff;
      acc_b_in      = acc_b_ff;
      mplr_c_in     = mplr_c_ff;
      mc_c_in       = mc_c_ff;
      acc_c_in      = acc_c_ff;
      num_in        = num_ff;
      num_neg_in    = num_neg_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      cmd_in        = cmd_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // Load the three lanes and remember the error for the next word.
               prior_in  = err;
               mag_in    = err_abs[11:0];
               eneg_in   = err[12];
               tdiv_in   = (sq_div_ff == 8'd0) ? 8'd1 : sq_div_ff;
               mplr_a_in = err_abs[11:0];
               mc_a_in   = {24'd0, err_abs[11:0]};
               acc_a_in  = '0;
               mplr_b_in = base_gain_ff;
               mc_b_in   = {{18{err[12]}}, err};
               acc_b_in  = '0;
               mplr_c_in = diff_gain_ff;
               mc_c_in   = {{8{delta[13]}}, delta};
               acc_c_in  = '0;
               cnt_in    = '0;
               state_in  = ST_MUL1;
            end
         end
         ST_MUL1, ST_MUL2: begin
            mplr_a_in = mplr_a_ff >> 1;
            mc_a_in   = mc_a_ff << 1;
            acc_a_in  = a_sum;
            mplr_b_in = mplr_b_ff >> 1;
            mc_b_in   = mc_b_ff <<< 1;
            acc_b_in  = b_sum;
            mplr_c_in = mplr_c_ff >> 1;
            mc_c_in   = mc_c_ff <<< 1;
            acc_c_in  = c_sum;
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in = '0;
               if (state_ff == ST_MUL1) begin
                  // Square times magnitude, divisor times the PD sum.
                  mplr_a_in = mag_ff;
                  mc_a_in   = a_sum;
                  acc_a_in  = '0;
                  mplr_b_in = tdiv_ff;
                  mc_b_in   = k_val;
                  acc_b_in  = '0;
                  state_in  = ST_MUL2;
               end else begin
                  state_in  = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            // Numerator: signed cube plus divisor times the PD sum.
            if (eneg_ff) begin
               num_in = {{7{acc_b_ff[30]}}, acc_b_ff} - {2'b00, acc_a_ff};
            end else begin
               num_in = {{7{acc_b_ff[30]}}, acc_b_ff} + {2'b00, acc_a_ff};
            end
            state_in = ST_ABS;
         end
         ST_ABS: begin
            num_neg_in = num_ff[37];
            div_in     = num_ff[37] ? num_negated[36:0] : num_ff[36:0];
            rem_in     = '0;
            cnt_in     = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial_diff[7:0] : trial[7:0];
            div_in = {div_ff[35:0], trial_ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Center minus the correction truncated toward zero.
            if (num_neg_ff) begin
               cmd_in = {23'd0, servo_center_ff} + {2'b00, div_ff};
            end else begin
               cmd_in = {23'd0, servo_center_ff} - {2'b00, div_ff};
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = sat;
               if (sat) begin
                  rsp_tdata_in = cmd_ff[38] ? CMD_MIN : CMD_MAX;
               end else begin
                  rsp_tdata_in = cmd_ff[31:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         prior_ff        <= '0;
         rsp_tvalid_ff   <= 1'b0;
         base_gain_ff    <= BASE_GAIN_RESET;
         diff_gain_ff    <= DIFF_GAIN_RESET;
         sq_div_ff       <= SQUARE_DIVISOR_RESET;
         servo_center_ff <= SERVO_CENTER_RESET;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         prior_ff      <= prior_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_BASE_GAIN:      base_gain_ff    <= csr_data[7:0];
               REG_DIFF_GAIN:      diff_gain_ff    <= csr_data[7:0];
               REG_SQUARE_DIVISOR: sq_div_ff       <= csr_data[7:0];
               REG_SERVO_CENTER:   servo_center_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      eneg_ff      <= eneg_in;
      tdiv_ff      <= tdiv_in;
      mplr_a_ff    <= mplr_a_in;
      mc_a_ff      <= mc_a_in;
      acc_a_ff     <= acc_a_in;
      mplr_b_ff    <= mplr_b_in;
      mc_b_ff      <= mc_b_in;
      acc_b_ff     <= acc_b_in;
      mplr_c_ff    <= mplr_c_in;
      mc_c_ff      <= mc_c_in;
      acc_c_ff     <= acc_c_in;
      num_ff       <= num_in;
      num_neg_ff   <= num_neg_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      cmd_ff       <= cmd_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // An accepted word always starts the first multiplier pass.
   `ASSERT_NEXT(a_fire_starts, clock, reset, req_fire, state_ff == ST_MUL1, "accepted word did not start")
   // The partial remainder stays below the divisor.
   `ASSERT_CLK(a_rem_bound, clock, reset, (state_ff != ST_DIV) || (rem_ff < tdiv_ff), "remainder out of range")
   // A clipped result carries one of the two limits.
   `ASSERT_CLK(a_clip_limit, clock, reset, !(rsp_tvalid_ff && rsp_tuser_ff) || (rsp_tdata_ff == CMD_MAX) || (rsp_tdata_ff == CMD_MIN), "clipped result not at a limit")
   // A finished word with a free output register is presented next cycle.
   `ASSERT_NEXT(a_out_shown, clock, reset, (state_ff == ST_OUT) && rsp_free, rsp_tvalid_ff && (state_ff == ST_IDLE), "finished word not presented")

endmodule
